// ===== hdl/fpsb_pkg.sv =====
// Shared types and constants for the five-point stencil blur.
// Field widths, register indexes, reset sizes, queue sizing and the divide-by-five reciprocal.
// No dependencies.
package fpsb_pkg;

   localparam int PIX_W = 8;
   localparam int ROW_W = 16;
   localparam int FW_W  = 13;
   localparam int FH_W  = 16;
   localparam int CSR_W = 16;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type REG_FRAME_WIDTH  = 1'b0;
   localparam csr_index_type REG_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 13'd1024;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd1024;
   localparam logic [FH_W-1:0] MIN_HEIGHT         = 16'd3;

   // floor(y/5) = (y * RECIP_5) >> RECIP_SHIFT, exact for y < 2048
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 18;
   localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

endpackage

// ===== hdl/five_point_stencil_blur.sv =====
// Five-point stencil blur: line buffers, raster counters, smoothing and result queue.
// Results of an accepted word are written into the result queue and shown from its head.
// Throughput: one word per cycle while req_stall is low; on the last row each word gives
// two results, so the result port holds the input back there.
// Reset: counters, hold pixel and result queue cleared, sizes set to 1024;
// line buffers are not cleared. Depends on fpsb_pkg.
module five_point_stencil_blur
   import fpsb_pkg::*;
#(
   parameter int MAX_WIDTH = 4096,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PIX_W-1:0]    req_pixel_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PIX_W-1:0]    rsp_pixel_out,
   output logic [ROW_W-1:0]    rsp_out_row,
   output logic [COL_W-1:0]    rsp_out_col,
   output logic                rsp_run_last,
   input  logic                csr_write,
   input  csr_index_type       csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   localparam int CNT_W = COL_W + 1;
   localparam int CMP_W = (CNT_W > FW_W) ? CNT_W : FW_W;
   localparam int SUM_W = PIX_W + 2;
   localparam int NUM_W = PIX_W + 5;
   localparam int Q_W   = NUM_W - 2;
   localparam int PRD_W = Q_W + RECIP_W;

   function automatic logic [CNT_W-1:0] clamp_width(input logic [FW_W-1:0] fw);
      logic [CMP_W-1:0] v;
      v = CMP_W'(fw);
      if (v < CMP_W'(3)) begin
         v = CMP_W'(3);
      end else if (v > CMP_W'(MAX_WIDTH)) begin
         v = CMP_W'(MAX_WIDTH);
      end
      return v[CNT_W-1:0];
   endfunction

   // sizes
   logic [FW_W-1:0]  width_ff, width_in;
   logic [FH_W-1:0]  height_ff, height_in;

   // raster state
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] hold_ff, hold_in;

   // line buffers and their registered reads
   logic [PIX_W-1:0] line_prev_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] line_prev2_ff [MAX_WIDTH];
   logic [PIX_W-1:0] prev_c_ff, prev_r_ff, prev2_c_ff;

   // result queue
   logic [PIX_W-1:0]      fifo_pix_ff  [FIFO_DEPTH];
   logic [ROW_W-1:0]      fifo_row_ff  [FIFO_DEPTH];
   logic [COL_W-1:0]      fifo_col_ff  [FIFO_DEPTH];
   logic                  fifo_last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   logic             accept, pop;
   logic [CNT_W-1:0] w_use, w_next, c_next;
   logic [FH_W-1:0]  h_use;
   logic             wrap_col, row_end, frame_end, last_row, border;
   logic [COL_W-1:0] c_eff, pre_col, pre_col_r;
   logic [CNT_W-1:0] pre_col_sum;
   logic [ROW_W:0]   row_step, r_next;
   logic [ROW_W-1:0] r_eff;
   logic [PIX_W-1:0] hold_eff, smooth, val;
   logic [SUM_W-1:0] sum;
   logic [NUM_W-1:0] num;
   logic [PRD_W-1:0] prod;
   logic [1:0]       push_n;
   logic [PIX_W-1:0] e0_pix, e1_pix;
   logic [ROW_W-1:0] e0_row, e1_row;
   logic             e0_last;

   assign req_stall = count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_pixel_out = fifo_pix_ff[rd_ptr_ff];
   assign rsp_out_row   = fifo_row_ff[rd_ptr_ff];
   assign rsp_out_col   = fifo_col_ff[rd_ptr_ff];
   assign rsp_run_last  = fifo_last_ff[rd_ptr_ff];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && csr_index == REG_FRAME_WIDTH) begin
         width_in = csr_data[FW_W-1:0];
      end
      if (csr_write && csr_index == REG_FRAME_HEIGHT) begin
         height_in = csr_data[FH_W-1:0];
      end
   end

   // position of the incoming word
   always_comb begin
      w_use     = clamp_width(width_ff);
      h_use     = (height_ff < MIN_HEIGHT) ? MIN_HEIGHT : height_ff;
      wrap_col  = {1'b0, col_ff} >= w_use;
      c_eff     = wrap_col ? '0 : col_ff;
      hold_eff  = wrap_col ? '0 : hold_ff;
      row_step  = {1'b0, row_ff} + {{ROW_W{1'b0}}, wrap_col};
      r_eff     = (row_step >= {1'b0, h_use}) ? '0 : row_step[ROW_W-1:0];
      c_next    = {1'b0, c_eff} + CNT_W'(1);
      r_next    = {1'b0, r_eff} + (ROW_W+1)'(1);
      row_end   = c_next >= w_use;
      frame_end = r_next >= {1'b0, h_use};
      last_row  = r_next == {1'b0, h_use};
      border    = (c_eff == '0) || row_end;
   end

   // (8*centre + 3*neighbours) / 20 as ((.. >> 2) * 1/5)
   always_comb begin
      sum    = SUM_W'(prev2_c_ff) + SUM_W'(req_pixel_in) + SUM_W'(hold_eff)
             + SUM_W'(prev_r_ff);
      num    = NUM_W'({prev_c_ff, 3'b000}) + NUM_W'(sum) + NUM_W'({sum, 1'b0});
      prod   = PRD_W'(num[NUM_W-1:2]) * PRD_W'(RECIP_5);
      smooth = prod[RECIP_SHIFT +: PIX_W];
      val    = border ? prev_c_ff : smooth;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      hold_in = hold_ff;
      if (accept) begin
         if (row_end) begin
            col_in  = '0;
            hold_in = '0;
            row_in  = frame_end ? '0 : r_next[ROW_W-1:0];
         end else begin
            col_in  = c_next[COL_W-1:0];
            row_in  = r_eff;
            hold_in = (r_eff == '0) ? hold_eff : prev_c_ff;
         end
      end
   end

   // read ahead for the word after this edge
   always_comb begin
      w_next      = clamp_width(width_in);
      pre_col     = ({1'b0, col_in} >= w_next) ? '0 : col_in;
      pre_col_sum = {1'b0, pre_col} + CNT_W'(1);
      pre_col_r   = pre_col_sum[COL_W-1:0];
   end

   always_comb begin
      push_n  = 2'd0;
      e0_pix  = req_pixel_in;
      e0_row  = r_eff;
      e0_last = 1'b1;
      e1_pix  = req_pixel_in;
      e1_row  = r_eff;
      if (accept) begin
         if (r_eff == '0) begin
            push_n = 2'd1;
         end else if (r_eff != ROW_W'(1)) begin
            e0_pix  = val;
            e0_row  = r_eff - ROW_W'(1);
            e0_last = !last_row;
            push_n  = last_row ? 2'd2 : 2'd1;
         end
      end
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         hold_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         hold_ff   <= hold_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_prev_ff[c_eff] <= req_pixel_in;
         if (r_eff != '0) begin
            line_prev2_ff[c_eff] <= prev_c_ff;
         end
      end
      prev_c_ff  <= line_prev_ff[pre_col];
      prev_r_ff  <= line_prev_ff[pre_col_r];
      prev2_c_ff <= line_prev2_ff[pre_col];
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_pix_ff[wr_ptr_ff]  <= e0_pix;
         fifo_row_ff[wr_ptr_ff]  <= e0_row;
         fifo_col_ff[wr_ptr_ff]  <= c_eff;
         fifo_last_ff[wr_ptr_ff] <= e0_last;
      end
      if (push_n == 2'd2) begin
         fifo_pix_ff[wr_ptr_ff + FIFO_PTR_W'(1)]  <= e1_pix;
         fifo_row_ff[wr_ptr_ff + FIFO_PTR_W'(1)]  <= e1_row;
         fifo_col_ff[wr_ptr_ff + FIFO_PTR_W'(1)]  <= c_eff;
         fifo_last_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= 1'b1;
      end
   end

endmodule

// ===== hdl/fpsb_checker.sv =====
// Port-level checks for five_point_stencil_blur, bound to the top level.
// Depends on fpsb_pkg and the top level's ports.
module fpsb_checker
   import fpsb_pkg::*;
#(
   parameter int MAX_WIDTH = 4096,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_pixel_out,
   input logic [ROW_W-1:0] rsp_out_row,
   input logic [COL_W-1:0] rsp_out_col,
   input logic             rsp_run_last
);

   // queue empties on reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // a held word keeps its contents
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // the pair from a last-row word is queued together
   a_pair_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("second result of a pair missing");

   // second of a pair is the pixel below, same column
   a_pair_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=>
         rsp_out_col == $past(rsp_out_col)
         && rsp_out_row == $past(rsp_out_row) + ROW_W'(1) && rsp_run_last)
      else $error("second result of a pair at wrong position");

endmodule

bind five_point_stencil_blur fpsb_checker #(.MAX_WIDTH(MAX_WIDTH)) u_fpsb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_run_last  (rsp_run_last)
);
